/* hw/rtl/pcxrle_pkg.sv */
// Shared types and constants of the PCX run-length framebuffer decoder.
package pcxrle_pkg;

  localparam int DATA_W       = 8;
  localparam int COUNT_W      = 6;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 11;
  localparam int STRIDE_W     = 12;
  localparam int ROW_W        = 10;
  localparam int PIX_ADDR_W   = 21;
  localparam int MAX_HEIGHT   = 1024;

  localparam int S_TDATA_W    = 8;
  localparam int M_TDATA_W    = 32;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE  = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd320;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 11'd200;
  localparam logic [STRIDE_W-1:0]     STRIDE_RESET = 12'd320;

  // run marker: both top bits set, count in the low six
  localparam logic [DATA_W-1:0] MARK_BITS = 8'hc0;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LITERAL,
    KIND_RUN
  } byte_kind_t;

  typedef struct packed {
    logic accept;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    byte_kind_t kind;
    logic       run_last;
    logic       out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/pcxrle_ctrl.sv */
// Controller state machine: input acceptance and run sequencing.
module pcxrle_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  pcxrle_pkg::dp_stat_t stat,
  output pcxrle_pkg::dp_cmd_t  cmd
);
  import pcxrle_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = stat.out_free;
        cmd.accept = s_tvalid && stat.out_free;
        if (cmd.accept && stat.kind == KIND_RUN) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        // one pixel per free output slot
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.run_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> !s_tready && !cmd.accept)
    else $error("input taken while a run is being emitted");

  a_run_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && stat.kind == KIND_RUN |=> state == ST_RUN)
    else $error("run value byte did not start a run");

endmodule

/* hw/rtl/pcxrle_dpath.sv */
// Datapath: config registers, decode state, address generation, output register.
module pcxrle_dpath #(
  parameter int MAX_WIDTH = 1024,
  parameter int ADDR_BITS = 21
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [pcxrle_pkg::DATA_W-1:0]         data_byte,
  input  logic                                  start_frame,
  input  pcxrle_pkg::dp_cmd_t                   cmd,
  output pcxrle_pkg::dp_stat_t                  stat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [pcxrle_pkg::DATA_W-1:0]         pixel_value,
  output logic [pcxrle_pkg::PIX_ADDR_W-1:0]     pixel_address,
  output logic                                  last_of_run,
  output logic                                  frame_done
);
  import pcxrle_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [STRIDE_W-1:0]     line_stride;

  logic                 run_pending;
  logic [COUNT_W-1:0]   run_length;
  logic [COL_W-1:0]     column;
  logic [ROW_W-1:0]     row;
  logic [ADDR_BITS-1:0] row_base;
  logic                 image_complete;
  logic [DATA_W-1:0]    run_value;

  logic                 restart;
  logic                 cur_pending;
  logic [COUNT_W-1:0]   cur_len;
  logic [COL_W-1:0]     cur_col;
  logic [ROW_W-1:0]     cur_row;
  logic [ADDR_BITS-1:0] cur_base;
  logic                 cur_cpl;

  logic [CMP_W-1:0]        eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic [CMP_W-1:0]        col_plus;
  logic [HEIGHT_REG_W-1:0] row_plus;
  logic                    line_end;
  logic                    done;
  logic                    cpl;
  byte_kind_t              kind;
  logic                    load_out;
  logic                    emit_last;
  logic [DATA_W-1:0]       emit_value;
  logic [ADDR_BITS-1:0]    addr;
  logic [ADDR_BITS+PIX_ADDR_W-1:0] addr_ext;

  // restart applies before the byte is used
  always_comb begin
    restart     = cmd.accept && start_frame;
    cur_pending = restart ? 1'b0 : run_pending;
    cur_len     = restart ? '0 : run_length;
    cur_col     = restart ? '0 : column;
    cur_row     = restart ? '0 : row;
    cur_base    = restart ? '0 : row_base;
    cur_cpl     = restart ? 1'b0 : image_complete;
  end

  always_comb begin
    if (image_width == '0) begin
      eff_w = CMP_W'(1);
    end else if (CMP_W'(image_width) > CMP_W'(MAX_WIDTH)) begin
      eff_w = CMP_W'(MAX_WIDTH);
    end else begin
      eff_w = CMP_W'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HEIGHT_REG_W'(1);
    end else if (image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
  end

  always_comb begin
    col_plus = CMP_W'(cur_col) + CMP_W'(1);
    row_plus = HEIGHT_REG_W'(cur_row) + HEIGHT_REG_W'(1);
    line_end = col_plus >= eff_w;
    done     = line_end && (row_plus >= eff_h);
    cpl      = cur_cpl || (HEIGHT_REG_W'(cur_row) >= eff_h);
    addr     = cur_base + ADDR_BITS'(cur_col);
    addr_ext = {{PIX_ADDR_W{1'b0}}, addr};
  end

  always_comb begin
    if (cpl) begin
      kind = KIND_NONE;
    end else if (cur_pending) begin
      kind = (cur_len != '0) ? KIND_RUN : KIND_NONE;
    end else if ((data_byte & MARK_BITS) == MARK_BITS) begin
      kind = KIND_NONE;
    end else begin
      kind = KIND_LITERAL;
    end
  end

  always_comb begin
    load_out   = (cmd.accept && kind == KIND_LITERAL) || cmd.step;
    emit_value = cmd.step ? run_value : data_byte;
    emit_last  = cmd.step ? ((run_length == COUNT_W'(1)) || done) : 1'b1;

    stat.kind     = kind;
    stat.run_last = (run_length == COUNT_W'(1)) || done;
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= WIDTH_RESET;
      image_height   <= HEIGHT_RESET;
      line_stride    <= STRIDE_RESET;
      run_pending    <= 1'b0;
      run_length     <= '0;
      column         <= '0;
      row            <= '0;
      row_base       <= '0;
      image_complete <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
          CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
          CFG_LINE_STRIDE:  line_stride  <= cfg_data[STRIDE_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end

      if (cmd.accept) begin
        column         <= cur_col;
        row            <= cur_row;
        row_base       <= cur_base;
        run_pending    <= cur_pending;
        run_length     <= cur_len;
        image_complete <= cur_cpl;
        if (cpl) begin
          image_complete <= 1'b1;
          run_pending    <= 1'b0;
          run_length     <= '0;
        end else if (cur_pending) begin
          // count kept as the remaining pixels of the run
          run_pending <= 1'b0;
        end else if ((data_byte & MARK_BITS) == MARK_BITS) begin
          run_pending <= 1'b1;
          run_length  <= data_byte[COUNT_W-1:0];
        end
      end

      if (cmd.step) begin
        run_length <= emit_last ? '0 : run_length - COUNT_W'(1);
      end

      if (load_out) begin
        if (done) begin
          image_complete <= 1'b1;
        end else if (line_end) begin
          column   <= '0;
          row      <= cur_row + ROW_W'(1);
          row_base <= cur_base + ADDR_BITS'(line_stride);
        end else begin
          column <= cur_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && kind == KIND_RUN) begin
      run_value <= data_byte;
    end
    if (load_out) begin
      pixel_value   <= emit_value;
      pixel_address <= addr_ext[PIX_ADDR_W-1:0];
      last_of_run   <= emit_last;
      frame_done    <= done;
    end
  end

  a_done_completes: assert property (@(posedge clk) disable iff (rst)
    load_out && done |=> image_complete)
    else $error("final pixel did not mark the image complete");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last_of_run)
    else $error("final pixel of image not flagged as last of run");

endmodule

/* hw/rtl/pcx_rle_framebuffer_decoder.sv */
// Top level of the PCX run-length decoder with framebuffer addressing.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: data_byte[7:0]; tuser: start_frame
//  m_*     | out | m_tvalid/m_tready  | tdata: pixel_value[7:0], pixel_address[28:8],
//          |     |                    |        zero[31:29]; tlast: last_of_run;
//          |     |                    |        tuser: frame_done
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data (width, height, stride)
//
// Literal, run marker and ignored bytes are each accepted on their own; the value byte
// of a run starts the run, and the input is held off while its pixels are emitted.
// The single output register sets the pace: one pixel per cycle at most.
// Reset is synchronous; no clearing pass.
// m_tready low holds the output register and, with it, holds off the input.
module pcx_rle_framebuffer_decoder #(
  parameter int MAX_WIDTH = 1024,
  parameter int ADDR_BITS = 21
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0]     cfg_data,
  // encoded byte stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [pcxrle_pkg::S_TDATA_W-1:0]      s_tdata,  // [7:0] data_byte
  input  logic                                  s_tuser,  // [0] start_frame
  // decoded pixels
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [pcxrle_pkg::M_TDATA_W-1:0]      m_tdata,  // [7:0] pixel_value,
                                                          // [28:8] pixel_address
  output logic                                  m_tlast,  // last_of_run
  output logic                                  m_tuser   // [0] frame_done
);
  import pcxrle_pkg::*;

  dp_cmd_t                 cmd;
  dp_stat_t                stat;
  logic [DATA_W-1:0]       pixel_value;
  logic [PIX_ADDR_W-1:0]   pixel_address;

  pcxrle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcxrle_dpath #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .data_byte     (s_tdata[DATA_W-1:0]),
    .start_frame   (s_tuser),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .pixel_value   (pixel_value),
    .pixel_address (pixel_address),
    .last_of_run   (m_tlast),
    .frame_done    (m_tuser)
  );

  // pad the pixel transfer to whole bytes
  assign m_tdata = {{(M_TDATA_W - DATA_W - PIX_ADDR_W){1'b0}}, pixel_address, pixel_value};

endmodule
